// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: transaction types, command codes
// and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    // Fixed field widths of the request and response transactions.
    localparam int unsigned CMD_BITS     = 2;
    localparam int unsigned KEY_BITS     = 8;
    localparam int unsigned PAYLOAD_BITS = 32;
    localparam int unsigned COUNT_BITS   = 5;

    // Command codes carried in the request.
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

    // Request transaction.
    typedef struct packed {
        logic [CMD_BITS-1:0]     cmd;
        logic [KEY_BITS-1:0]     severity;
        logic [PAYLOAD_BITS-1:0] payload;
    } req_t;

    // Response transaction.
    typedef struct packed {
        logic                    ok;
        logic [KEY_BITS-1:0]     out_severity;
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic [COUNT_BITS-1:0]   count;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a response this cycle
        logic do_insert;
        logic do_remove;
        logic do_clear;
        logic ok;         // the accepted operation is carried out
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
    } dp_stat_t;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: the response is registered and appears in the cycle
// after its request is accepted, and the queue takes one request per cycle while
// rsp_ready stays high.
// Reset clears the count and the response valid; entry storage is not reset.
// Top level; depends on spq_pkg, spq_ctrl and spq_datapath.
`timescale 1ns / 1ps

module sorted_priority_queue
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  spq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output spq_pkg::rsp_t  rsp
);

    spq_pkg::dp_cmd_t  dp_cmd;
    spq_pkg::dp_stat_t dp_stat;

    // Handshake and command decode.
    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_cmd   (req.cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // Entry row, count and response register.
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (dp_cmd),
        .stat  (dp_stat),
        .rsp   (rsp)
    );

endmodule

// ===== rtl/spq_ctrl.sv =====
// Controller for the sorted priority queue: handshake state machine and
// command decode. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [spq_pkg::CMD_BITS-1:0]        req_cmd,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  spq_pkg::dp_stat_t                   stat,
    output spq_pkg::dp_cmd_t                    cmd
);

    // One-hot states: no response held, or a response waiting to be taken.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   exec;

    // A new request is taken whenever the output register is free or is
    // being emptied in this cycle.
    assign req_ready = (state_reg == ST_IDLE) || rsp_ready;
    assign rsp_valid = (state_reg == ST_HOLD);
    assign exec      = req_valid && req_ready;

    // Command decode, qualified by the queue status.
    always_comb
    begin
        cmd           = '0;
        cmd.load      = exec;
        case (req_cmd)
            spq_pkg::CMD_INSERT:
            begin
                cmd.do_insert = exec && !stat.full;
                cmd.ok        = !stat.full;
            end
            spq_pkg::CMD_REMOVE:
            begin
                cmd.do_remove = exec && !stat.empty;
                cmd.ok        = !stat.empty;
            end
            spq_pkg::CMD_CLEAR:
            begin
                cmd.do_clear  = exec && !stat.empty;
                cmd.ok        = !stat.empty;
            end
            default:
            begin
                cmd.ok        = 1'b0;
            end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (exec)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!exec && rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/spq_datapath.sv =====
// Datapath for the sorted priority queue: sorted entry row with parallel
// compare-and-shift, occupancy count and response register. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_datapath
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  spq_pkg::req_t                           req,
    input  spq_pkg::dp_cmd_t                        cmd,
    output spq_pkg::dp_stat_t                       stat,
    output spq_pkg::rsp_t                           rsp
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [spq_pkg::KEY_BITS-1:0]     key_reg  [DEPTH];
    logic [spq_pkg::PAYLOAD_BITS-1:0] data_reg [DEPTH];
    logic [CNT_W-1:0]                 occ_reg;
    logic [CNT_W-1:0]                 occ_next;
    spq_pkg::rsp_t                    rsp_reg;
    logic [DEPTH-1:0]                 stays;     // entry sorts at or before the new key
    logic [DEPTH-1:0]                 lead;      // preceding entry stays (or slot 0)
    logic [CNT_W+spq_pkg::COUNT_BITS-1:0] cnt_ext;

    assign stat.empty = (occ_reg == '0);
    assign stat.full  = (occ_reg == CNT_W'(DEPTH));

    // Compare every held entry with the new key at once. Since the row is
    // sorted, the set of entries that stay in place is a prefix.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            stays[i] = (CNT_W'(i) < occ_reg) && (key_reg[i] <= req.severity);
        end
    end

    assign lead = {stays[DEPTH-2:0], 1'b1};

    // Each slot either keeps its entry, takes the new one, or takes its
    // neighbor's entry on an insert or a remove.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_slot
        always_ff @(posedge clk)
        begin
            if (cmd.do_insert && !stays[g])
            begin
                if (lead[g])
                begin
                    key_reg[g]  <= req.severity;
                    data_reg[g] <= req.payload;
                end
                else
                begin
                    if (g > 0)
                    begin
                        key_reg[g]  <= key_reg[(g > 0) ? g - 1 : 0];
                        data_reg[g] <= data_reg[(g > 0) ? g - 1 : 0];
                    end
                end
            end
            else if (cmd.do_remove && (g < DEPTH - 1))
            begin
                key_reg[g]  <= key_reg[(g < DEPTH - 1) ? g + 1 : g];
                data_reg[g] <= data_reg[(g < DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    // Occupancy update.
    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.do_insert)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (cmd.do_remove)
        begin
            occ_next = occ_reg - 1'b1;
        end
        else if (cmd.do_clear)
        begin
            occ_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Response register; the count field keeps the low bits of the occupancy.
    assign cnt_ext = {{spq_pkg::COUNT_BITS{1'b0}}, occ_next};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsp_reg.ok           <= cmd.ok;
            rsp_reg.out_severity <= cmd.do_remove ? key_reg[0] : '0;
            rsp_reg.out_payload  <= cmd.do_remove ? data_reg[0] : '0;
            rsp_reg.count        <= cnt_ext[spq_pkg::COUNT_BITS-1:0];
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/spq_checker.sv =====
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
`timescale 1ns / 1ps

module spq_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input spq_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input spq_pkg::rsp_t rsp
);

    // A response that is not taken stays and holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response dropped or changed while stalled");

    // Every accepted request gives a response in the next cycle.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("no response after an accepted request");

    // A clear always leaves the queue empty.
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.cmd == spq_pkg::CMD_CLEAR)
        |=> rsp.count == '0)
        else $error("count not zero after clear");

    // An undefined command is never carried out.
    a_bad_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.cmd != spq_pkg::CMD_INSERT)
        && (req.cmd != spq_pkg::CMD_REMOVE) && (req.cmd != spq_pkg::CMD_CLEAR)
        |=> !rsp.ok)
        else $error("undefined command reported success");

    // A refused transaction returns no entry data.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> (rsp.out_severity == '0) && (rsp.out_payload == '0))
        else $error("refused transaction returned entry data");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== test/tb_sorted_priority_queue.sv =====
// Self-checking testbench for sorted_priority_queue: directed and random
// transactions, a built-in priority queue predictor and a result scoreboard.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

    localparam int unsigned QUEUE_DEPTH    = 16;
    localparam int unsigned RANDOM_ITEMS   = 420;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned TAIL_CYCLES    = 4;
    localparam int unsigned REPORT_LIMIT   = 10;

    // The one command encoding that the queue ignores.
    localparam logic [spq_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    // A staged request, optionally held back until every result is in.
    typedef struct {
        spq_pkg::req_t req;
        bit            wait_drained;
    } staged_req_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    spq_pkg::req_t  req = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    spq_pkg::rsp_t  rsp;

    // Predicted queue contents, kept sorted by ascending severity.
    logic [spq_pkg::KEY_BITS-1:0]     held_key [QUEUE_DEPTH];
    logic [spq_pkg::PAYLOAD_BITS-1:0] held_data[QUEUE_DEPTH];
    int unsigned                      held_count = 0;

    staged_req_t   req_backlog[$];
    spq_pkg::rsp_t owed_rsp[$];

    int unsigned staged_total = 0;
    int unsigned staged_held = 0;
    int unsigned fault_count = 0;
    int unsigned send_pause = 0;
    int unsigned take_pause = 0;
    int unsigned idle_cycles = 0;
    bit          send_steady = 1'b0;
    bit          take_steady = 1'b0;

    sorted_priority_queue
    #(
        .DEPTH(QUEUE_DEPTH)
    )
    dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Applies one request to the predicted queue and returns the response it owes.
    function automatic spq_pkg::rsp_t apply_request(spq_pkg::req_t r);
        spq_pkg::rsp_t res;
        int unsigned   pos;
        res = '0;
        case (r.cmd)
            spq_pkg::CMD_INSERT:
            begin
                if (held_count < QUEUE_DEPTH)
                begin
                    // Equal keys stay in arrival order: skip past them.
                    pos = 0;
                    while (pos < held_count && held_key[pos] <= r.severity)
                        pos++;
                    for (int i = int'(held_count); i > int'(pos); i--)
                    begin
                        held_key[i]  = held_key[i-1];
                        held_data[i] = held_data[i-1];
                    end
                    held_key[pos]  = r.severity;
                    held_data[pos] = r.payload;
                    held_count++;
                    res.ok = 1'b1;
                end
            end
            spq_pkg::CMD_REMOVE:
            begin
                if (held_count > 0)
                begin
                    res.out_severity = held_key[0];
                    res.out_payload  = held_data[0];
                    for (int i = 1; i < int'(held_count); i++)
                    begin
                        held_key[i-1]  = held_key[i];
                        held_data[i-1] = held_data[i];
                    end
                    held_count--;
                    res.ok = 1'b1;
                end
            end
            spq_pkg::CMD_CLEAR:
            begin
                if (held_count > 0)
                begin
                    held_count = 0;
                    res.ok = 1'b1;
                end
            end
            default:
            begin
                res.ok = 1'b0;
            end
        endcase
        res.count = spq_pkg::COUNT_BITS'(held_count);
        return res;
    endfunction

    // Idle cycles drawn per transaction; steady stretches use none.
    function automatic int unsigned draw_pause(bit steady);
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    // Keys lean toward the extremes and a narrow band that forces ties.
    function automatic logic [spq_pkg::KEY_BITS-1:0] draw_severity();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
        else if (pick == 1)
            return spq_pkg::KEY_BITS'($urandom_range(120, 123));
        else
            return spq_pkg::KEY_BITS'($urandom_range(0, 255));
    endfunction

    // Queues one request and tracks the occupancy it leaves behind.
    task automatic stage(input logic [spq_pkg::CMD_BITS-1:0] cmd,
                         input logic [spq_pkg::KEY_BITS-1:0] sev,
                         input logic [spq_pkg::PAYLOAD_BITS-1:0] pay,
                         input bit wait_drained);
        staged_req_t item;
        item.req.cmd      = cmd;
        item.req.severity = sev;
        item.req.payload  = pay;
        item.wait_drained = wait_drained;
        req_backlog.push_back(item);
        staged_total++;
        case (cmd)
            spq_pkg::CMD_INSERT: if (staged_held < QUEUE_DEPTH) staged_held++;
            spq_pkg::CMD_REMOVE: if (staged_held > 0) staged_held--;
            spq_pkg::CMD_CLEAR:  staged_held = 0;
            default:             staged_held = staged_held;
        endcase
    endtask

    // Fills the queue, pushes a few refused inserts, then empties it.
    task automatic stage_fill();
        while (staged_held < QUEUE_DEPTH)
            stage(spq_pkg::CMD_INSERT, draw_severity(), $urandom, 1'b0);
        repeat ($urandom_range(1, 3))
            stage(spq_pkg::CMD_INSERT, draw_severity(), $urandom, 1'b0);
        if ($urandom_range(0, 1) == 0)
        begin
            while (staged_held > 0)
                stage(spq_pkg::CMD_REMOVE, draw_severity(), $urandom, 1'b0);
            stage(spq_pkg::CMD_REMOVE, draw_severity(), $urandom, 1'b0);
        end
        else
        begin
            stage(spq_pkg::CMD_CLEAR, draw_severity(), $urandom, 1'b0);
        end
    endtask

    // Request driver: one transaction at a time from the backlog.
    always @(posedge clk or negedge rst_n)
    begin
        staged_req_t next_item;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                owed_rsp.push_back(apply_request(req));
                if ($urandom_range(0, 39) == 0)
                    send_steady = !send_steady;
                send_pause = draw_pause(send_steady);
            end
            if (req_valid && !req_ready)
            begin
                // Hold the current transaction until it is taken.
            end
            else if (send_pause > 0)
            begin
                send_pause--;
                req_valid <= 1'b0;
            end
            else if (req_backlog.size() != 0 &&
                     !(req_backlog[0].wait_drained && owed_rsp.size() != 0))
            begin
                next_item = req_backlog.pop_front();
                req <= next_item.req;
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response monitor: checks each transaction against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        spq_pkg::rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            if (owed_rsp.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display({"%0t: response with none expected: ",
                              "ok=%0b sev=%0h pay=%0h count=%0d"},
                             $realtime, rsp.ok, rsp.out_severity, rsp.out_payload,
                             rsp.count);
            end
            else
            begin
                want = owed_rsp.pop_front();
                if (rsp.ok !== want.ok || rsp.out_severity !== want.out_severity ||
                    rsp.out_payload !== want.out_payload || rsp.count !== want.count)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display({"%0t: mismatch: expected ok=%0b sev=%0h pay=%0h ",
                                  "count=%0d, got ok=%0b sev=%0h pay=%0h count=%0d"},
                                 $realtime, want.ok, want.out_severity, want.out_payload,
                                 want.count, rsp.ok, rsp.out_severity, rsp.out_payload,
                                 rsp.count);
                end
            end
            if ($urandom_range(0, 39) == 0)
                take_steady = !take_steady;
            take_pause = draw_pause(take_steady);
            rsp_ready <= (take_pause == 0);
        end
        else if (take_pause > 0)
        begin
            take_pause--;
            rsp_ready <= (take_pause == 0);
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_sorted_priority_queue: done, errors");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int unsigned directed_total;
        int unsigned pick;

        // Refusals on an empty queue, including the ignored command.
        stage(spq_pkg::CMD_REMOVE, 8'hff, 32'hffff_ffff, 1'b0);
        stage(spq_pkg::CMD_CLEAR, 8'h00, 32'h0000_0000, 1'b0);
        stage(CMD_UNUSED, 8'hff, 32'hffff_ffff, 1'b0);
        // Extreme keys and payloads, then three ties that must leave in order.
        stage(spq_pkg::CMD_INSERT, 8'hff, 32'hffff_ffff, 1'b0);
        stage(spq_pkg::CMD_INSERT, 8'h00, 32'h0000_0000, 1'b0);
        stage(spq_pkg::CMD_INSERT, 8'h80, 32'haaaa_5555, 1'b0);
        stage(spq_pkg::CMD_INSERT, 8'h80, 32'h5555_aaaa, 1'b0);
        stage(spq_pkg::CMD_INSERT, 8'h80, 32'h0123_4567, 1'b0);
        stage(CMD_UNUSED, 8'h01, 32'h8000_0001, 1'b0);
        stage(spq_pkg::CMD_REMOVE, 8'h00, 32'h0000_0000, 1'b0);
        stage(spq_pkg::CMD_REMOVE, 8'h00, 32'h0000_0000, 1'b0);
        stage(spq_pkg::CMD_INSERT, 8'h80, 32'hdead_beef, 1'b1);
        stage(spq_pkg::CMD_INSERT, 8'h7f, 32'h7fff_ffff, 1'b0);
        stage(spq_pkg::CMD_REMOVE, 8'h00, 32'h0000_0000, 1'b0);
        stage(spq_pkg::CMD_REMOVE, 8'h00, 32'h0000_0000, 1'b0);
        stage(spq_pkg::CMD_REMOVE, 8'h00, 32'h0000_0000, 1'b0);
        stage(spq_pkg::CMD_REMOVE, 8'h00, 32'h0000_0000, 1'b0);
        stage(spq_pkg::CMD_REMOVE, 8'h00, 32'h0000_0000, 1'b0);
        stage(spq_pkg::CMD_REMOVE, 8'h00, 32'h0000_0000, 1'b0);
        stage(spq_pkg::CMD_INSERT, 8'h42, 32'h0000_0042, 1'b0);
        stage(spq_pkg::CMD_INSERT, 8'h41, 32'h0000_0041, 1'b0);
        stage(spq_pkg::CMD_CLEAR, 8'hff, 32'hffff_ffff, 1'b0);
        stage(spq_pkg::CMD_REMOVE, 8'h00, 32'h0000_0000, 1'b0);
        directed_total = staged_total;

        // Random part: full-queue sweeps mixed with runs of random operations.
        stage_fill();
        while (staged_total < directed_total + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                stage_fill();
            end
            else
            begin
                repeat ($urandom_range(8, 30))
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        stage(spq_pkg::CMD_INSERT, draw_severity(), $urandom,
                              $urandom_range(0, 19) == 0);
                    else if (pick < 85)
                        stage(spq_pkg::CMD_REMOVE, draw_severity(), $urandom,
                              $urandom_range(0, 19) == 0);
                    else if (pick < 92)
                        stage(spq_pkg::CMD_CLEAR, draw_severity(), $urandom, 1'b0);
                    else
                        stage(CMD_UNUSED, draw_severity(), $urandom, 1'b0);
                end
            end
        end

        // Hold reset, then release it.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request is taken and every response checked.
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || req_valid || owed_rsp.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fault_count == 0 && owed_rsp.size() == 0)
            $display("tb_sorted_priority_queue: done, clean");
        else
            $display("tb_sorted_priority_queue: done, errors");
        $finish;
    end

endmodule
